/* hw/rtl/mfs_pkg.sv */
// ----------------------------------------------------------------------------
// mfs_pkg
// Types, constants and elaboration-time sigmoid table builder for the
// three-neuron two-layer perceptron.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int NEURONS    = 3;
	localparam int DATA_W     = 16;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int FRAC_BITS  = 12;
	localparam int SH_W       = ACC_W - FRAC_BITS;
	localparam int ROW_W      = NEURONS * DATA_W;
	localparam int NUM_REGS   = 2 * NEURONS;
	localparam int CFG_IDX_W  = 3;
	localparam int CELLS      = NEURONS;
	localparam int SIG_LAT    = 5;
	localparam int LAYER_LAT  = CELLS + SIG_LAT;

	localparam logic [CFG_IDX_W-1:0] REG_HID_ROW0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HID_ROW1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HID_ROW2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ROW0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ROW1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ROW2 = 3'd5;

	localparam logic [DATA_W-1:0] Q12_MAX = 16'h7fff;
	localparam logic [DATA_W-1:0] Q12_MIN = 16'h8000;

	typedef logic signed [DATA_W-1:0] q12_t;
	typedef q12_t [NEURONS-1:0] vec_t;
	typedef logic [NEURONS-1:0][ACC_W-1:0] acc_vec_t;
	typedef logic [NEURONS-1:0][DATA_W-1:0] act_vec_t;
	typedef logic [NEURONS-1:0][ROW_W-1:0] rows_t;

	typedef struct packed {
		logic     valid;
		vec_t     x;
		acc_vec_t acc;
	} mac_bus_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] in_a;
		logic signed [DATA_W-1:0] in_b;
		logic signed [DATA_W-1:0] in_c;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0] hid_a;
		logic [DATA_W-1:0] hid_b;
		logic [DATA_W-1:0] hid_c;
		logic [DATA_W-1:0] out_a;
		logic [DATA_W-1:0] out_b;
		logic [DATA_W-1:0] out_c;
	} out_t;

	// restoring divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^(-y), y and result in q30
	function automatic logic [63:0] exp_neg_small(input logic [63:0] y);
		logic signed [63:0] sum;
		logic [63:0]        term;
		sum  = 64'sd1 <<< 30;
		term = 64'd1 << 30;
		for (int n = 1; n <= 12; n++) begin
			term = udiv64((term * y) >> 30, 64'(n));
			if ((n % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		return $unsigned(sum);
	endfunction

	function automatic logic [DATA_W-1:0] sig_entry(input int entries, input int k);
		logic signed [63:0] m;
		logic               neg;
		logic [63:0]        a;
		logic [63:0]        y;
		logic [63:0]        e;
		logic [63:0]        d;
		logic [63:0]        r;
		m   = 64'(16 * k) - 64'(8 * entries);
		neg = (m < 0);
		a   = neg ? $unsigned(-m) : $unsigned(m);
		y   = udiv64(a << 26, 64'(entries));
		e   = exp_neg_small(y);
		for (int i = 0; i < 4; i++) begin
			e = (e * e) >> 30;
		end
		d = (64'd1 << 30) + e;
		if (neg) begin
			r = udiv64((e << 15) + (d >> 1), d);
		end else begin
			r = udiv64((64'd1 << 45) + (d >> 1), d);
		end
		return r[DATA_W-1:0];
	endfunction

endpackage

/* hw/rtl/mfs_mac_cell.sv */
// ----------------------------------------------------------------------------
// mfs_mac_cell
// One multiply-accumulate cell: adds the head input times its weight column
// to every neuron's partial sum and rotates the input vector to the next cell.
// ----------------------------------------------------------------------------
module mfs_mac_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mfs_pkg::mac_bus_t bus_in,
	input  mfs_pkg::vec_t     w_col,
	output mfs_pkg::mac_bus_t bus_out
);

	logic [mfs_pkg::NEURONS-1:0][mfs_pkg::PROD_W-1:0] prod;
	mfs_pkg::acc_vec_t                                acc_nx;
	mfs_pkg::vec_t                                    x_nx;
	logic                                             valid_q;
	mfs_pkg::acc_vec_t                                acc_q;
	mfs_pkg::vec_t                                    x_q;

	always_comb begin
		for (int n = 0; n < mfs_pkg::NEURONS; n++) begin
			prod[n]   = $signed(bus_in.x[0]) * $signed(w_col[n]);
			acc_nx[n] = bus_in.acc[n] + mfs_pkg::ACC_W'($signed(prod[n]));
			x_nx[n]   = bus_in.x[(n == mfs_pkg::NEURONS - 1) ? 0 : n + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= bus_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_nx;
		x_q   <= x_nx;
	end

	assign bus_out.valid = valid_q;
	assign bus_out.x     = x_q;
	assign bus_out.acc   = acc_q;

endmodule

/* hw/rtl/mfs_sigmoid.sv */
// ----------------------------------------------------------------------------
// mfs_sigmoid
// Five-stage sigmoid for all neurons of a layer: shift and saturate, table
// index, table read, step times fraction, final add.
// ----------------------------------------------------------------------------
module mfs_sigmoid #(
	parameter int ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  mfs_pkg::acc_vec_t acc_in,
	output logic              valid_out,
	output mfs_pkg::act_vec_t act
);

	localparam int IW = $clog2(ENTRIES + 1);
	localparam int PW = mfs_pkg::DATA_W + IW;
	localparam int DW = mfs_pkg::DATA_W;

	logic [DW-1:0]                    rom [ENTRIES+1];
	logic [mfs_pkg::SIG_LAT-1:0]      vld_q;
	logic [mfs_pkg::NEURONS-1:0][DW-1:0] u_s1;
	logic [mfs_pkg::NEURONS-1:0][IW-1:0] idx_s2;
	logic [mfs_pkg::NEURONS-1:0][DW-1:0] frac_s2;
	logic [mfs_pkg::NEURONS-1:0][DW-1:0] frac_s3;
	logic [mfs_pkg::NEURONS-1:0][DW-1:0] lo_s3;
	logic [mfs_pkg::NEURONS-1:0][DW-1:0] hi_s3;
	logic [mfs_pkg::NEURONS-1:0][DW-1:0] lo_s4;
	logic [mfs_pkg::NEURONS-1:0]         neg_s4;
	logic [mfs_pkg::NEURONS-1:0][2*DW-1:0] prod_s4;
	mfs_pkg::act_vec_t                   act_s5;

	for (genvar k = 0; k <= ENTRIES; k++) begin : g_rom
		localparam logic [DW-1:0] VAL = mfs_pkg::sig_entry(ENTRIES, k);
		assign rom[k] = VAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[mfs_pkg::SIG_LAT-2:0], valid_in};
		end
	end

	for (genvar n = 0; n < mfs_pkg::NEURONS; n++) begin : g_lane
		logic [mfs_pkg::SH_W-1:0] sh;
		logic [DW-1:0]            sat;
		logic [PW-1:0]            p;
		logic [IW-1:0]            idx_nx;
		logic [DW-1:0]            mag;
		logic [DW-1:0]            step;

		assign sh = acc_in[n][mfs_pkg::ACC_W-1:mfs_pkg::FRAC_BITS];

		always_comb begin
			if (!sh[mfs_pkg::SH_W-1] && (sh[mfs_pkg::SH_W-2:DW-1] != '0)) begin
				sat = mfs_pkg::Q12_MAX;
			end else if (sh[mfs_pkg::SH_W-1] && (sh[mfs_pkg::SH_W-2:DW-1] != '1)) begin
				sat = mfs_pkg::Q12_MIN;
			end else begin
				sat = sh[DW-1:0];
			end
		end

		assign p      = PW'(u_s1[n]) * PW'(ENTRIES);
		assign idx_nx = idx_s2[n] + IW'(1);
		assign mag    = (hi_s3[n] >= lo_s3[n]) ? hi_s3[n] - lo_s3[n] : lo_s3[n] - hi_s3[n];
		assign step   = prod_s4[n][2*DW-1:DW];

		always_ff @(posedge clk) begin
			u_s1[n]    <= sat ^ mfs_pkg::Q12_MIN;
			idx_s2[n]  <= p[PW-1:DW];
			frac_s2[n] <= p[DW-1:0];
			lo_s3[n]   <= rom[idx_s2[n]];
			hi_s3[n]   <= rom[idx_nx];
			frac_s3[n] <= frac_s2[n];
			lo_s4[n]   <= lo_s3[n];
			neg_s4[n]  <= (hi_s3[n] < lo_s3[n]);
			prod_s4[n] <= (2*DW)'(mag) * (2*DW)'(frac_s3[n]);
			act_s5[n]  <= neg_s4[n] ? lo_s4[n] - step : lo_s4[n] + step;
		end
	end

	assign valid_out = vld_q[mfs_pkg::SIG_LAT-1];
	assign act       = act_s5;

endmodule

/* hw/rtl/mfs_layer.sv */
// ----------------------------------------------------------------------------
// mfs_layer
// One perceptron layer: a row of multiply-accumulate cells followed by the
// sigmoid pipeline.
// ----------------------------------------------------------------------------
module mfs_layer #(
	parameter int ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  mfs_pkg::vec_t     x_in,
	input  mfs_pkg::rows_t    rows,
	output logic              valid_out,
	output mfs_pkg::act_vec_t act
);

	mfs_pkg::mac_bus_t bus [mfs_pkg::CELLS+1];

	always_comb begin
		bus[0].valid = valid_in;
		bus[0].x     = x_in;
		bus[0].acc   = '0;
	end

	for (genvar c = 0; c < mfs_pkg::CELLS; c++) begin : g_cell
		mfs_pkg::vec_t w_col;

		for (genvar n = 0; n < mfs_pkg::NEURONS; n++) begin : g_w
			assign w_col[n] = rows[n][mfs_pkg::DATA_W*c +: mfs_pkg::DATA_W];
		end

		mfs_mac_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bus_in  (bus[c]),
			.w_col   (w_col),
			.bus_out (bus[c+1])
		);
	end

	mfs_sigmoid #(
		.ENTRIES (ENTRIES)
	) u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (bus[mfs_pkg::CELLS].valid),
		.acc_in    (bus[mfs_pkg::CELLS].acc),
		.valid_out (valid_out),
		.act       (act)
	);

endmodule

/* hw/rtl/mlp_forward_3x3x3_sigmoid.sv */
// ----------------------------------------------------------------------------
// mlp_forward_3x3x3_sigmoid
// Two-layer, three-neuron perceptron with sigmoid activations in fixed point.
//
//   channel   ports                          moves
//   input     start, busy, in_word           one word of three q3.12 inputs
//   result    done, out_word                 one word of six q1.15 activations
//   config    cfg_we, cfg_idx, cfg_data      one 48-bit weight row
//
// one word accepted every cycle, busy is always low
// each layer is three mac cells and a five-stage sigmoid
// reset clears the weight rows and all valid flags
// done is a single-cycle strobe, the receiver cannot stall
// ----------------------------------------------------------------------------
module mlp_forward_3x3x3_sigmoid #(
	parameter int SIGMOID_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  mfs_pkg::in_t                      in_word,
	input  logic                              cfg_we,
	input  logic [mfs_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mfs_pkg::ROW_W-1:0]         cfg_data,
	output logic                              done,
	output mfs_pkg::out_t                     out_word
);

	logic [mfs_pkg::NUM_REGS-1:0][mfs_pkg::ROW_W-1:0] weights_q;
	mfs_pkg::rows_t    hid_rows;
	mfs_pkg::rows_t    out_rows;
	logic              accept;
	mfs_pkg::vec_t     x1;
	mfs_pkg::vec_t     x2;
	logic              valid1;
	logic              valid2;
	mfs_pkg::act_vec_t act1;
	mfs_pkg::act_vec_t act2;
	mfs_pkg::act_vec_t hid_dly_q [mfs_pkg::LAYER_LAT];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				mfs_pkg::REG_HID_ROW0: weights_q[0] <= cfg_data;
				mfs_pkg::REG_HID_ROW1: weights_q[1] <= cfg_data;
				mfs_pkg::REG_HID_ROW2: weights_q[2] <= cfg_data;
				mfs_pkg::REG_OUT_ROW0: weights_q[3] <= cfg_data;
				mfs_pkg::REG_OUT_ROW1: weights_q[4] <= cfg_data;
				mfs_pkg::REG_OUT_ROW2: weights_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int n = 0; n < mfs_pkg::NEURONS; n++) begin
			hid_rows[n] = weights_q[n];
			out_rows[n] = weights_q[mfs_pkg::NEURONS + n];
			x2[n]       = {3'b000, act1[n][mfs_pkg::DATA_W-1:3]};
		end
	end

	assign x1 = {in_word.in_c, in_word.in_b, in_word.in_a};

	mfs_layer #(
		.ENTRIES (SIGMOID_ENTRIES)
	) u_hidden (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (accept),
		.x_in      (x1),
		.rows      (hid_rows),
		.valid_out (valid1),
		.act       (act1)
	);

	mfs_layer #(
		.ENTRIES (SIGMOID_ENTRIES)
	) u_output (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid1),
		.x_in      (x2),
		.rows      (out_rows),
		.valid_out (valid2),
		.act       (act2)
	);

	// hidden activations ride alongside the second layer
	always_ff @(posedge clk) begin
		hid_dly_q[0] <= act1;
		for (int i = 1; i < mfs_pkg::LAYER_LAT; i++) begin
			hid_dly_q[i] <= hid_dly_q[i-1];
		end
	end

	assign done           = valid2;
	assign out_word.hid_a = hid_dly_q[mfs_pkg::LAYER_LAT-1][0];
	assign out_word.hid_b = hid_dly_q[mfs_pkg::LAYER_LAT-1][1];
	assign out_word.hid_c = hid_dly_q[mfs_pkg::LAYER_LAT-1][2];
	assign out_word.out_a = act2[0];
	assign out_word.out_b = act2[1];
	assign out_word.out_c = act2[2];

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2 * mfs_pkg::LAYER_LAT))
		else $error("result word without a matching input word");

	a_hid_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid1, mfs_pkg::LAYER_LAT))
		else $error("hidden activations out of step with output layer");

	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_word.hid_a <= 16'd32768 && out_word.hid_b <= 16'd32768 &&
			out_word.hid_c <= 16'd32768 && out_word.out_a <= 16'd32768 &&
			out_word.out_b <= 16'd32768 && out_word.out_c <= 16'd32768))
		else $error("activation above one");

endmodule
